// ----- sv/ica_pkg.sv -----
`timescale 1ns / 1ps
// ica_pkg: shared types and constants for the instrument channel allocator
// no dependencies

package ica_pkg;

    // request codes carried on the req_type port
    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAP  = 2'd1,
        ST_CHAN = 2'd2
    } state_t;

    // command group from the control fsm to the channel store
    typedef struct packed {
        logic rd;
        logic wr;
        logic set_valid;
        logic clr_valid;
        logic clr_all;
    } chan_cmd_t;

    localparam int CH_FIELD_W = 4;

endpackage

// ----- sv/ica_map_ram.sv -----
`timescale 1ns / 1ps
// ica_map_ram: instrument to channel map, single port write, registered read
// depends on nothing; instantiated by instrument_channel_allocator

module ica_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 4
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] map_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ica_chan_store.sv -----
`timescale 1ns / 1ps
// ica_chan_store: per-channel owner and count memory, owner valid bits
// and the lowest free channel search; uses ica_pkg

module ica_chan_store #(
    parameter int CHANNELS = 16,
    parameter int CW       = 4,
    parameter int IW       = 7,
    parameter int NW       = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ica_pkg::chan_cmd_t  cmd,
    input  logic [CW-1:0]       rd_addr,
    input  logic [CW-1:0]       wr_addr,
    input  logic [IW-1:0]       wr_owner,
    input  logic [NW-1:0]       wr_count,
    output logic [IW-1:0]       rd_owner,
    output logic [NW-1:0]       rd_count,
    output logic                rd_valid,
    output logic                free_any,
    output logic [CW-1:0]       free_idx
);

    import ica_pkg::*;

    logic [IW-1:0]       owner_mem [CHANNELS];
    logic [NW-1:0]       count_mem [CHANNELS];
    logic [CHANNELS-1:0] owner_valid_reg;
    logic [CHANNELS-1:0] owner_valid_next;
    logic [IW-1:0]       rd_owner_reg;
    logic [NW-1:0]       rd_count_reg;
    logic                rd_valid_reg;
    logic                free_any_reg;
    logic [CW-1:0]       free_idx_reg;
    logic                free_any_c;
    logic [CW-1:0]       free_idx_c;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            owner_mem[wr_addr] <= wr_owner;
            count_mem[wr_addr] <= wr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_owner_reg <= owner_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_valid_reg <= owner_valid_reg[rd_addr];
            free_any_reg <= free_any_c;
            free_idx_reg <= free_idx_c;
        end
    end

    // lowest index wins
    always_comb
    begin
        free_any_c = 1'b0;
        free_idx_c = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (!owner_valid_reg[i])
            begin
                free_any_c = 1'b1;
                free_idx_c = CW'(i);
            end
        end
    end

    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        if (cmd.clr_all)
        begin
            owner_valid_next = '0;
        end
        else if (cmd.set_valid)
        begin
            owner_valid_next[wr_addr] = 1'b1;
        end
        else if (cmd.clr_valid)
        begin
            owner_valid_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= '0;
        end
        else
        begin
            owner_valid_reg <= owner_valid_next;
        end
    end

    assign rd_owner = rd_owner_reg;
    assign rd_count = rd_count_reg;
    assign rd_valid = rd_valid_reg;
    assign free_any = free_any_reg;
    assign free_idx = free_idx_reg;

endmodule

// ----- sv/instrument_channel_allocator.sv -----
`timescale 1ns / 1ps
// instrument_channel_allocator: reference counted instrument to channel binding
// one request in flight at a time: map ram read, channel store read, then update, held while rsp_stall
// reset: asynchronous; clears the fsm, the output valid and the channel valid
//   bits at once, so no clearing pass; ram contents are checked against owners
// depends on ica_pkg, ica_map_ram, ica_chan_store

module instrument_channel_allocator #(
    parameter int CHANNELS    = 16,
    parameter int INSTRUMENTS = 128,
    parameter int COUNT_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] req_type,
    input  logic [6:0] instrument,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [3:0] channel,
    output logic       ok,
    output logic       new_assignment
);

    import ica_pkg::*;

    localparam int CW = $clog2(CHANNELS);
    localparam int IW = $clog2(INSTRUMENTS);
    localparam int NW = COUNT_WIDTH;
    localparam logic [15:0] INS_LIMIT = 16'(INSTRUMENTS);

    state_t        state_reg;
    state_t        state_next;
    req_t          req_reg;
    logic [IW-1:0] ins_reg;
    logic          range_reg;

    logic [15:0]   ins_wide;
    logic [IW-1:0] ins_addr;
    logic          ins_in_range;

    logic          map_rd_en;
    logic          map_wr_en;
    logic [CW-1:0] map_q;

    chan_cmd_t     chan_cmd;
    logic [CW-1:0] chan_wr_addr;
    logic [NW-1:0] chan_wr_count;
    logic [IW-1:0] chan_owner;
    logic [NW-1:0] chan_count;
    logic          chan_valid;
    logic          free_any;
    logic [CW-1:0] free_idx;

    logic          mapped;
    logic [NW-1:0] count_inc;
    logic [NW-1:0] count_dec;
    logic          go;
    logic          act_wr;
    logic          act_set;
    logic          act_clr;
    logic          act_clr_all;
    logic          act_map;
    logic [CW-1:0] res_ch;
    logic          res_ok;
    logic          res_new;
    logic [15:0]   res_ch_wide;
    logic          load_out;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [CH_FIELD_W-1:0] channel_reg;
    logic                  ok_reg;
    logic                  new_reg;

    assign ins_wide     = 16'(instrument);
    assign ins_addr     = ins_wide[IW-1:0];
    assign ins_in_range = ins_wide < INS_LIMIT;

    ica_map_ram #(
        .DEPTH (INSTRUMENTS),
        .AW    (IW),
        .DW    (CW)
    ) u_map (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (ins_addr),
        .wr_en   (map_wr_en),
        .wr_addr (ins_reg),
        .wr_data (free_idx),
        .rd_data (map_q)
    );

    ica_chan_store #(
        .CHANNELS (CHANNELS),
        .CW       (CW),
        .IW       (IW),
        .NW       (NW)
    ) u_chan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (chan_cmd),
        .rd_addr  (map_q),
        .wr_addr  (chan_wr_addr),
        .wr_owner (ins_reg),
        .wr_count (chan_wr_count),
        .rd_owner (chan_owner),
        .rd_count (chan_count),
        .rd_valid (chan_valid),
        .free_any (free_any),
        .free_idx (free_idx)
    );

    // a stale map entry is harmless: the channel must still name this owner
    assign mapped    = chan_valid && (chan_owner == ins_reg);
    assign count_inc = (chan_count == {NW{1'b1}}) ? chan_count : chan_count + NW'(1);
    assign count_dec = (chan_count == '0) ? '0 : chan_count - NW'(1);
    assign go        = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        act_wr        = 1'b0;
        act_set       = 1'b0;
        act_clr       = 1'b0;
        act_clr_all   = 1'b0;
        act_map       = 1'b0;
        chan_wr_addr  = map_q;
        chan_wr_count = count_inc;
        res_ch        = '0;
        res_ok        = 1'b0;
        res_new       = 1'b0;
        unique case (req_reg)
            REQ_ACQUIRE:
            begin
                if (range_reg && mapped)
                begin
                    res_ch = map_q;
                    res_ok = 1'b1;
                    act_wr = 1'b1;
                end
                else if (range_reg && free_any)
                begin
                    res_ch        = free_idx;
                    res_ok        = 1'b1;
                    res_new       = 1'b1;
                    act_wr        = 1'b1;
                    act_set       = 1'b1;
                    act_map       = 1'b1;
                    chan_wr_addr  = free_idx;
                    chan_wr_count = NW'(1);
                end
            end
            REQ_RELEASE:
            begin
                if (range_reg && mapped)
                begin
                    res_ch        = map_q;
                    res_ok        = 1'b1;
                    chan_wr_count = count_dec;
                    if (count_dec == '0)
                    begin
                        act_clr = 1'b1;
                    end
                    else
                    begin
                        act_wr = 1'b1;
                    end
                end
            end
            REQ_CLEAR:
            begin
                res_ok      = 1'b1;
                act_clr_all = 1'b1;
            end
            REQ_NONE:
            begin
                res_ok = 1'b0;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        map_rd_en  = 1'b0;
        map_wr_en  = 1'b0;
        chan_cmd   = '0;
        load_out   = 1'b0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    map_rd_en  = 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                chan_cmd.rd = 1'b1;
                state_next  = ST_CHAN;
            end
            ST_CHAN:
            begin
                if (go)
                begin
                    chan_cmd.wr        = act_wr;
                    chan_cmd.set_valid = act_set;
                    chan_cmd.clr_valid = act_clr;
                    chan_cmd.clr_all   = act_clr_all;
                    map_wr_en          = act_map;
                    load_out           = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_rd_en)
        begin
            req_reg   <= req_t'(req_type);
            ins_reg   <= ins_addr;
            range_reg <= ins_in_range;
        end
    end

    assign rsp_valid_next = load_out ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign res_ch_wide = 16'(res_ch);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            channel_reg <= res_ch_wide[CH_FIELD_W-1:0];
            ok_reg      <= res_ok;
            new_reg     <= res_new;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign channel        = channel_reg;
    assign ok             = ok_reg;
    assign new_assignment = new_reg;

    // a failed word carries no channel and no new binding
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> channel == '0 && !new_assignment)
        else $error("failed result with nonzero channel or new flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && new_assignment |-> ok)
        else $error("new assignment flagged on a failed result");

    // one request in flight: after an accept the input side stalls through the map and channel states
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall ##1 req_stall)
        else $error("request accepted while another is in flight");

    // a result word appears only when the channel stage completes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_CHAN))
        else $error("result word without a completed request");

endmodule

// ----- verif/tb_instrument_channel_allocator.sv -----
`timescale 1ns / 1ps
// tb_instrument_channel_allocator: self-checking bench for the channel allocator
// depends on ica_pkg and instrument_channel_allocator

module tb_instrument_channel_allocator;
    import ica_pkg::*;

    localparam int          NUM_CH   = 16;
    localparam int          NUM_INS  = 128;
    localparam logic [7:0]  USE_MAX  = 8'hFF;
    localparam int          HOLD_LEN = 80;

    typedef struct packed {
        logic [3:0] channel;
        logic       ok;
        logic       fresh;
    } alloc_result_t;

    // binding table and reference counts, mirrored from the block
    class alloc_scoreboard;
        bit            bound    [NUM_INS];
        logic [3:0]    bound_ch [NUM_INS];
        bit            ch_busy  [NUM_CH];
        logic [7:0]    use_count[NUM_CH];
        alloc_result_t expected_q[$];
        int            errors;

        function new();
            errors = 0;
            unbind_all();
        endfunction

        function void unbind_all();
            foreach (bound[i])
            begin
                bound[i]    = 1'b0;
                bound_ch[i] = 4'd0;
            end
            foreach (ch_busy[i])
            begin
                ch_busy[i]   = 1'b0;
                use_count[i] = 8'd0;
            end
        endfunction

        function void note_request(req_t kind, logic [6:0] ins);
            alloc_result_t res;
            int c;
            res = '0;
            case (kind)
                REQ_CLEAR:
                begin
                    unbind_all();
                    res.ok = 1'b1;
                end
                REQ_ACQUIRE:
                begin
                    if (bound[ins])
                    begin
                        c = bound_ch[ins];
                        if (use_count[c] != USE_MAX)
                            use_count[c] = use_count[c] + 8'd1;
                        res.channel = c[3:0];
                        res.ok      = 1'b1;
                    end
                    else
                    begin
                        for (c = 0; c < NUM_CH; c++)
                            if (!ch_busy[c])
                                break;
                        // lowest free channel, or failure when the pool is full
                        if (c < NUM_CH)
                        begin
                            bound[ins]    = 1'b1;
                            bound_ch[ins] = c[3:0];
                            ch_busy[c]    = 1'b1;
                            use_count[c]  = 8'd1;
                            res.channel   = c[3:0];
                            res.ok        = 1'b1;
                            res.fresh     = 1'b1;
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    if (bound[ins])
                    begin
                        c = bound_ch[ins];
                        if (use_count[c] != 8'd0)
                            use_count[c] = use_count[c] - 8'd1;
                        if (use_count[c] == 8'd0)
                        begin
                            ch_busy[c]    = 1'b0;
                            bound[ins]    = 1'b0;
                            bound_ch[ins] = 4'd0;
                        end
                        res.channel = c[3:0];
                        res.ok      = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(logic [3:0] ch, logic ok_bit, logic fresh_bit);
            alloc_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: channel %0d ok %0b new_assignment %0b",
                       ch, ok_bit, fresh_bit);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (ch !== want.channel)
            begin
                $error("channel: expected %0d, got %0d", want.channel, ch);
                errors++;
            end
            if (ok_bit !== want.ok)
            begin
                $error("ok: expected %0b, got %0b", want.ok, ok_bit);
                errors++;
            end
            if (fresh_bit !== want.fresh)
            begin
                $error("new_assignment: expected %0b, got %0b", want.fresh, fresh_bit);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic [1:0] req_type = REQ_ACQUIRE;
    logic [6:0] instrument = 7'd0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    logic [3:0] channel;
    logic       ok;
    logic       new_assignment;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_armed  = 1'b0;

    alloc_scoreboard sb = new();

    instrument_channel_allocator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .instrument     (instrument),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .channel        (channel),
        .ok             (ok),
        .new_assignment (new_assignment)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                rsp_stall <= 1'b1;
                for (n = 0; n < HOLD_LEN; n++)
                    @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(channel, ok, new_assignment);

    // offer one word and wait until it is taken; valid stays high afterwards
    task automatic send_word(req_t kind, logic [6:0] ins);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        instrument <= ins;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(kind, ins);
    endtask

    task automatic send_random(logic [6:0] window_base);
        int   pick;
        req_t kind;
        logic [6:0] ins;
        pick = $urandom_range(99);
        if (pick < 52)
            kind = REQ_ACQUIRE;
        else if (pick < 94)
            kind = REQ_RELEASE;
        else if (pick < 95)
            kind = REQ_CLEAR;
        else
            kind = REQ_NONE;
        // a window slightly wider than the pool keeps hits, misses and full pool common
        if ($urandom_range(99) < 85)
            ins = window_base + 7'($urandom_range(19));
        else
            ins = 7'($urandom);
        send_word(kind, ins);
    endtask

    initial
    begin
        int i;
        int phase;
        int waited;
        logic [6:0] base;
        logic [6:0] hot;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: binding, sharing, freeing, bad codes, full pool
        send_word(REQ_CLEAR,   7'd0);
        send_word(REQ_ACQUIRE, 7'd0);
        send_word(REQ_ACQUIRE, 7'd0);
        send_word(REQ_ACQUIRE, 7'd127);
        send_word(REQ_RELEASE, 7'd0);
        send_word(REQ_RELEASE, 7'd0);
        send_word(REQ_RELEASE, 7'd0);
        send_word(REQ_ACQUIRE, 7'd85);
        send_word(REQ_RELEASE, 7'd127);
        send_word(REQ_NONE,    7'd127);
        send_word(REQ_RELEASE, 7'd42);
        send_word(REQ_CLEAR,   7'd127);
        for (i = 0; i < NUM_CH; i++)
            send_word(REQ_ACQUIRE, 7'(112 + i));
        send_word(REQ_ACQUIRE, 7'd42);
        send_word(REQ_CLEAR,   7'd0);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 53;
                end
                1:
                begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 9;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            base = 7'($urandom_range(108));
            for (i = 0; i < 180; i++)
            begin
                if (i % 60 == 59)
                    base = 7'($urandom_range(108));
                // back pressure: the receiver holds off and the stall reaches the sender
                if (phase == 2 && i == 20)
                    hold_armed = 1'b1;
                send_random(base);
            end

            // drive one count past its maximum, then drop everything
            if (phase == 0)
            begin
                hot = 7'($urandom);
                for (i = 0; i < 262; i++)
                    send_word(REQ_ACQUIRE, hot);
                send_word(REQ_RELEASE, hot);
                send_word(REQ_CLEAR, 7'($urandom));
            end
        end

        @(posedge clk);
        req_valid <= 1'b0;

        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (sb.expected_q.size() != 0)
            $error("%0d result words never arrived", sb.expected_q.size());
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
